@@ rtl/core/vsls_pkg.sv @@
// ----------------------------------------------------------------------------
// vsls_pkg: shared types and constants of the vector/scalar load-store unit
// Memory geometry, access codes, bank command and pipeline stage records,
// and the byte-select helpers used by the issue and format logic.
// ----------------------------------------------------------------------------
package vsls_pkg;

    // Memory geometry: data memory is split into 16 byte-wide banks
    localparam int MEM_BYTES = 4096;
    localparam int ADDR_W    = $clog2(MEM_BYTES);
    localparam int NUM_BANKS = 16;
    localparam int OFS_W     = $clog2(NUM_BANKS);
    localparam int ROWS      = MEM_BYTES / NUM_BANKS;
    localparam int ROW_W     = ADDR_W - OFS_W;

    // Request and result field widths
    localparam int ACT_W     = 4;
    localparam int IN_ADDR_W = 12;
    localparam int WORD_W    = 32;
    localparam int HALF_W    = 64;
    localparam int VEC_W     = 2 * HALF_W;
    localparam int VEC_BYTES = VEC_W / 8;

    // Access codes
    typedef enum logic [ACT_W-1:0] {
        ACT_LB  = 4'd0,
        ACT_LBU = 4'd1,
        ACT_LH  = 4'd2,
        ACT_LHU = 4'd3,
        ACT_LW  = 4'd4,
        ACT_SB  = 4'd5,
        ACT_SH  = 4'd6,
        ACT_SW  = 4'd7,
        ACT_LQV = 4'd8,
        ACT_LRV = 4'd9,
        ACT_SQV = 4'd10
    } t_action;

    // Command to one byte bank
    typedef struct packed {
        logic             we;
        logic             re;
        logic [ROW_W-1:0] row;
        logic [7:0]       wdata;
    } t_bank_cmd;

    // Request held while the banks return read data
    typedef struct packed {
        t_action          action;
        logic [OFS_W-1:0] ofs;
        logic             mis;
        logic [VEC_W-1:0] vector;
    } t_stage;

    // Pick register byte idx; byte 0 sits in the top bits
    function automatic logic [7:0] vec_byte(logic [VEC_W-1:0] v, logic [OFS_W-1:0] idx);
        return v[(VEC_BYTES - 1 - int'(idx)) * 8 +: 8];
    endfunction

    // Pick scalar byte idx of a big-endian word
    function automatic logic [7:0] word_byte(logic [WORD_W-1:0] d, logic [1:0] idx);
        return d[(3 - int'(idx)) * 8 +: 8];
    endfunction

endpackage

@@ rtl/core/vsls_ram.sv @@
// ----------------------------------------------------------------------------
// vsls_ram: generic single-port synchronous RAM
// One access per cycle, write or read; read data is registered and holds
// until the next read.
// ----------------------------------------------------------------------------
module vsls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write or read one entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/vsls_issue.sv @@
// ----------------------------------------------------------------------------
// vsls_issue: bank command generation
// Maps one request onto the 16 byte banks: row per bank (scalar accesses
// carry into the next row and wrap at the end of memory), read enables for
// loads and per-byte write enables and data for stores.
// ----------------------------------------------------------------------------
module vsls_issue (
    input  logic                                          i_accept,
    input  vsls_pkg::t_action                             i_action,
    input  logic [vsls_pkg::ADDR_W-1:0]                   i_addr,
    input  logic [vsls_pkg::WORD_W-1:0]                   i_store_data,
    input  logic [vsls_pkg::VEC_W-1:0]                    i_vector,
    output vsls_pkg::t_bank_cmd [vsls_pkg::NUM_BANKS-1:0] o_cmd
);
    import vsls_pkg::*;

    logic [OFS_W-1:0] ofs;
    logic [ROW_W-1:0] row0;
    logic             is_scalar;
    logic             is_load;
    logic             vec_ok;

    // Split the address into row and byte offset
    assign ofs  = i_addr[OFS_W-1:0];
    assign row0 = i_addr[ADDR_W-1:OFS_W];

    // Classify the request
    assign is_scalar = (i_action == ACT_LB) || (i_action == ACT_LBU) ||
                       (i_action == ACT_LH) || (i_action == ACT_LHU) ||
                       (i_action == ACT_LW) || (i_action == ACT_SB)  ||
                       (i_action == ACT_SH) || (i_action == ACT_SW);
    assign is_load   = (i_action == ACT_LB)  || (i_action == ACT_LBU) ||
                       (i_action == ACT_LH)  || (i_action == ACT_LHU) ||
                       (i_action == ACT_LW)  || (i_action == ACT_LQV) ||
                       (i_action == ACT_LRV);
    assign vec_ok    = !i_addr[0];

    // Build one command per bank
    always_comb begin : bank_cmd
        logic [OFS_W-1:0] k;
        logic             wrap;
        for (int b = 0; b < NUM_BANKS; b++) begin
            k    = OFS_W'(b) - ofs;
            wrap = OFS_W'(b) < ofs;
            o_cmd[b].row   = row0 + ROW_W'(is_scalar && wrap);
            o_cmd[b].re    = i_accept && is_load;
            o_cmd[b].we    = 1'b0;
            o_cmd[b].wdata = 8'h00;
            unique case (i_action)
                ACT_SB: begin
                    o_cmd[b].we    = i_accept && (k == OFS_W'(0));
                    o_cmd[b].wdata = i_store_data[7:0];
                end
                ACT_SH: begin
                    o_cmd[b].we    = i_accept && (k < OFS_W'(2));
                    o_cmd[b].wdata = word_byte(i_store_data, 2'(k) + 2'd2);
                end
                ACT_SW: begin
                    o_cmd[b].we    = i_accept && (k < OFS_W'(4));
                    o_cmd[b].wdata = word_byte(i_store_data, 2'(k));
                end
                ACT_SQV: begin
                    o_cmd[b].we    = i_accept && vec_ok && !wrap;
                    o_cmd[b].wdata = vec_byte(i_vector, k);
                end
                default: begin
                end
            endcase
        end
    end

endmodule

@@ rtl/core/vsls_format.sv @@
// ----------------------------------------------------------------------------
// vsls_format: result assembly
// Turns the 16 bank read bytes of a held request into the scalar load
// value (sign or zero extended) and the merged vector register.
// ----------------------------------------------------------------------------
module vsls_format (
    input  vsls_pkg::t_stage                              i_stage,
    input  logic [vsls_pkg::NUM_BANKS-1:0][7:0]           i_rdata,
    output logic [vsls_pkg::WORD_W-1:0]                   o_load_data,
    output logic [vsls_pkg::VEC_W-1:0]                    o_vector,
    output logic                                          o_mis
);
    import vsls_pkg::*;

    logic [7:0] b0, b1, b2, b3;

    // Gather scalar bytes starting at the offset bank, wrapping across banks
    assign b0 = i_rdata[i_stage.ofs];
    assign b1 = i_rdata[i_stage.ofs + OFS_W'(1)];
    assign b2 = i_rdata[i_stage.ofs + OFS_W'(2)];
    assign b3 = i_rdata[i_stage.ofs + OFS_W'(3)];

    // Extend the scalar load value
    always_comb begin
        unique case (i_stage.action)
            ACT_LB:  o_load_data = {{24{b0[7]}}, b0};
            ACT_LBU: o_load_data = {24'h000000, b0};
            ACT_LH:  o_load_data = {{16{b0[7]}}, b0, b1};
            ACT_LHU: o_load_data = {16'h0000, b0, b1};
            ACT_LW:  o_load_data = {b0, b1, b2, b3};
            default: o_load_data = '0;
        endcase
    end

    // Merge memory bytes into the old register: quad loads take the bytes
    // from the offset to the block end, rest loads the bytes before it
    always_comb begin : vec_merge
        logic [OFS_W:0] sum;
        logic           take;
        logic           is_vload;
        is_vload = (i_stage.action == ACT_LQV) || (i_stage.action == ACT_LRV);
        o_vector = '0;
        for (int j = 0; j < VEC_BYTES; j++) begin
            sum  = (OFS_W+1)'(j) + {1'b0, i_stage.ofs};
            take = !i_stage.mis &&
                   (((i_stage.action == ACT_LQV) && !sum[OFS_W]) ||
                    ((i_stage.action == ACT_LRV) &&  sum[OFS_W]));
            if (is_vload) begin
                o_vector[(VEC_BYTES - 1 - j) * 8 +: 8] =
                    take ? i_rdata[sum[OFS_W-1:0]] : vec_byte(i_stage.vector, OFS_W'(j));
            end
        end
    end

    assign o_mis = i_stage.mis;

endmodule

@@ rtl/core/vector_scalar_load_store_unit.sv @@
// ----------------------------------------------------------------------------
// vector_scalar_load_store_unit: big-endian load/store unit with data memory
//
// Input channel (i_valid / o_stall) carries one access request: scalar
// byte, halfword or word load or store, quad or rest vector load, or quad
// vector store. Output channel (o_valid / i_stall) returns exactly one
// result per request: load value, merged vector register and misaligned.
// Memory is 16 byte-wide banks of MEM_BYTES/16 rows, one port each; a
// request touches every bank at most once, so it is served in one access.
// The result is registered in the bank read, then in the output register.
// Throughput: one request per cycle while the output is not stalled, set by
// the single port of each bank; stores and loads alternate freely.
// Reset clears the pipeline valid bits only; memory contents are undefined
// until written, and no clearing pass runs.
// While i_stall is high the output holds, one more request is taken into
// the read stage, and then o_stall rises until the output drains.
// ----------------------------------------------------------------------------
module vector_scalar_load_store_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [vsls_pkg::ACT_W-1:0]    i_action,
    input  logic [vsls_pkg::IN_ADDR_W-1:0] i_address,
    input  logic [vsls_pkg::WORD_W-1:0]   i_store_data,
    input  logic [vsls_pkg::HALF_W-1:0]   i_vector_in_high,
    input  logic [vsls_pkg::HALF_W-1:0]   i_vector_in_low,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [vsls_pkg::WORD_W-1:0]   o_load_data,
    output logic [vsls_pkg::HALF_W-1:0]   o_vector_out_high,
    output logic [vsls_pkg::HALF_W-1:0]   o_vector_out_low,
    output logic                          o_misaligned
);
    import vsls_pkg::*;

    t_action                         action;
    logic [ADDR_W-1:0]               addr;
    logic [VEC_W-1:0]                vector;
    logic                            accept;
    logic                            s1_adv;
    t_bank_cmd [NUM_BANKS-1:0]       cmd;
    logic [NUM_BANKS-1:0][7:0]       rdata;
    logic [WORD_W-1:0]               fmt_load;
    logic [VEC_W-1:0]                fmt_vector;
    logic                            fmt_mis;

    logic                            r_s1_valid;
    logic                            n_s1_valid;
    t_stage                          r_s1;
    logic                            r_out_valid;
    logic                            n_out_valid;
    logic [WORD_W-1:0]               r_load_data;
    logic [VEC_W-1:0]                r_vector;
    logic                            r_mis;

    // Decode the request
    assign action = t_action'(i_action);
    assign addr   = ADDR_W'(i_address);
    assign vector = {i_vector_in_high, i_vector_in_low};

    // Handshake: the read stage advances when the output register is empty or drains
    assign s1_adv  = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_s1_valid && !s1_adv;
    assign accept  = i_valid && !o_stall;

    // Bank commands
    vsls_issue u_issue (
        .i_accept     (accept),
        .i_action     (action),
        .i_addr       (addr),
        .i_store_data (i_store_data),
        .i_vector     (vector),
        .o_cmd        (cmd)
    );

    // Byte banks
    for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
        vsls_ram #(
            .WIDTH (8),
            .DEPTH (ROWS)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (cmd[b].we),
            .i_re    (cmd[b].re),
            .i_addr  (cmd[b].row),
            .i_wdata (cmd[b].wdata),
            .o_rdata (rdata[b])
        );
    end

    // Result assembly from the held request and bank data
    vsls_format u_format (
        .i_stage     (r_s1),
        .i_rdata     (rdata),
        .o_load_data (fmt_load),
        .o_vector    (fmt_vector),
        .o_mis       (fmt_mis)
    );

    // Next valid bits of the read stage and the output register
    always_comb begin
        n_s1_valid  = r_s1_valid;
        n_out_valid = r_out_valid;
        if (s1_adv) begin
            n_s1_valid  = 1'b0;
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
        if (accept) begin
            n_s1_valid = 1'b1;
        end
    end

    // Hold valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Capture the request and the result
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1.action <= action;
            r_s1.ofs    <= addr[OFS_W-1:0];
            r_s1.mis    <= ((action == ACT_LQV) || (action == ACT_LRV) ||
                            (action == ACT_SQV)) && addr[0];
            r_s1.vector <= vector;
        end
        if (s1_adv) begin
            r_load_data <= fmt_load;
            r_vector    <= fmt_vector;
            r_mis       <= fmt_mis;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_load_data       = r_load_data;
    assign o_vector_out_high = r_vector[VEC_W-1:HALF_W];
    assign o_vector_out_low  = r_vector[HALF_W-1:0];
    assign o_misaligned      = r_mis;

endmodule
